// ===== rtl/rlwts_pkg.sv =====
// ----------------------------------------------------------------------------
// rlwts_pkg
// shared types, constants and helpers of the reservation/limit/weight scheduler
// ----------------------------------------------------------------------------
package rlwts_pkg;

  localparam int TENANTS_DEF = 16;
  localparam int PENDING_DEF = 64;

  localparam int TAG_W   = 48;
  localparam int RATE_W  = 16;
  localparam int DIV_NW  = 42;   // dividend / quotient width of the divider
  localparam int PROD_W  = 26;   // 1000 * 16-bit count

  localparam logic [TAG_W-1:0]  TAG_MAX      = {TAG_W{1'b1}};
  localparam logic [TAG_W-1:0]  MS_ONE       = 48'd65536;
  localparam logic [TAG_W-1:0]  REBASE_LIMIT = 48'd655;
  localparam logic [9:0]        MS_PER_S     = 10'd1000;

  localparam logic REG_RRATE = 1'b0;
  localparam logic REG_LRATE = 1'b1;

  localparam logic [1:0] STAT_QUEUED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_GRANTED = 2'd2;
  localparam logic [1:0] STAT_NONE    = 2'd3;

  localparam logic REQ_INSERT   = 1'b0;
  localparam logic REQ_SCHEDULE = 1'b1;

  localparam logic METHOD_RES    = 1'b0;
  localparam logic METHOD_WEIGHT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  tenant;
    logic [15:0] request_id;
    logic [15:0] rho;
    logic [15:0] delta;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_id;
    logic [3:0]  granted_tenant;
    logic        method;
  } out_t;

  typedef struct packed {
    logic [15:0]      request;
    logic [3:0]       tenant;
    logic [TAG_W-1:0] rtag;
    logic [TAG_W-1:0] ltag;
    logic [TAG_W-1:0] ptag;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FREE, ST_RDIV, ST_LDIV, ST_PMIN, ST_PSUB, ST_PUPD, ST_WRITE,
    ST_SCAN, ST_DRAIN, ST_DECIDE, ST_DDIV, ST_DEC, ST_DECEND, ST_OUT
  } state_e;

  function automatic logic [TAG_W-1:0] sat_add(input logic [TAG_W-1:0] a,
                                               input logic [TAG_W-1:0] b);
    logic [TAG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TAG_W] ? TAG_MAX : s[TAG_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] tag_max(input logic [TAG_W-1:0] a,
                                               input logic [TAG_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/reservation_limit_weight_tag_scheduler.sv =====
// ----------------------------------------------------------------------------
// reservation_limit_weight_tag_scheduler
// mclock-style reservation / limit / proportion tag scheduler for one gate
// ----------------------------------------------------------------------------
// Each beat in produces exactly one beat out. An insert searches the valid
// bits for the lowest free slot (one slot a cycle, up to PENDING_DEPTH), runs
// two divisions on the shared restoring divider for the reservation and limit
// increments, optionally rebases the priority tags (two passes over the
// tenants), then writes the slot. A schedule beat scans the pending memory
// one slot a cycle, and a weight-based grant adds one division for the
// reservation decrement plus a read-modify-write sweep over the memory's
// single port pair. The input is ready only in the idle state; a finished
// result sits in the output register while the next beat is taken. Tags are
// unsigned 32.16 ms and saturate.
// ----------------------------------------------------------------------------
module reservation_limit_weight_tag_scheduler #(
  parameter int TENANTS       = rlwts_pkg::TENANTS_DEF,
  parameter int PENDING_DEPTH = rlwts_pkg::PENDING_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlwts_pkg::in_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlwts_pkg::out_t     out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);
  import rlwts_pkg::*;

  localparam int TIW = (TENANTS > 1) ? $clog2(TENANTS) : 1;
  localparam int SW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // configuration
  logic [RATE_W-1:0] rrate_q, lrate_q, rrate_eff, lrate_eff;

  // sequencer
  state_e st_q, st_d;
  in_t    in_q;
  logic [TAG_W-1:0] now_q;
  logic [TIW-1:0]   ten_q, tcnt_q, ten_idx;
  logic [SW-1:0]    cnt_q, slot_q, gidx_q;
  logic [3:0]       gten_q;
  out_t             res_q, out_q;
  logic             out_valid_q;

  // per-tenant tags
  logic [TAG_W-1:0] rtag_q [TENANTS];
  logic [TAG_W-1:0] ltag_q [TENANTS];
  logic [TAG_W-1:0] ptag_q [TENANTS];
  logic [TAG_W-1:0] pm_q;
  logic             pm_any_q;

  // pending table
  logic [PENDING_DEPTH-1:0] valid_q;
  slot_t            mem [PENDING_DEPTH];
  slot_t            rd_q, mem_wdata;
  logic             mem_we, mem_re;
  logic [SW-1:0]    mem_waddr;
  logic             pend_q, pend_dec_q;
  logic [SW-1:0]    pend_idx_q;

  // running minima of the scan
  logic             rany_q, pany_q;
  logic [TAG_W-1:0] rmin_q, pmin_q;
  logic [15:0]      rmin_id_q, pmin_id_q;
  logic [3:0]       rmin_ten_q, pmin_ten_q;
  logic [SW-1:0]    rmin_idx_q, pmin_idx_q;

  // divider
  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_dividend, div_quot;
  logic [RATE_W-1:0] div_divisor;
  logic [DIV_NW-1:0] dec_q;
  logic [PROD_W-1:0] prod;

  logic cnt_last, tcnt_last, out_load, r_better, p_better, r_due;
  logic [TAG_W-1:0] dec_tag;

  assign rrate_eff = (rrate_q == '0) ? RATE_W'(1) : rrate_q;
  assign lrate_eff = (lrate_q == '0) ? RATE_W'(1) : lrate_q;
  assign cnt_last  = (cnt_q == SW'(PENDING_DEPTH - 1));
  assign tcnt_last = (tcnt_q == TIW'(TENANTS - 1));
  assign dec_tag   = TAG_W'(dec_q);

  // tenant field folded into range
  always_comb begin
    ten_idx = '0;
    for (int v = 0; v < 16; v++) begin
      if (in_data_i.tenant == 4'(v)) ten_idx = TIW'(v % TENANTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rrate_q <= 16'd100;
      lrate_q <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RRATE: rrate_q <= cfg_wdata_i;
        REG_LRATE: lrate_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) begin
        st_d = (in_data_i.req_type == REQ_INSERT) ? ST_FREE : ST_SCAN;
      end
      ST_FREE: if (!valid_q[cnt_q]) begin
        st_d = ST_RDIV;
      end else if (cnt_last) begin
        st_d = ST_OUT;
      end
      ST_RDIV: if (div_done) st_d = ST_LDIV;
      ST_LDIV: if (div_done) begin
        st_d = (ptag_q[ten_q] <= REBASE_LIMIT) ? ST_PMIN : ST_PUPD;
      end
      ST_PMIN: if (tcnt_last) st_d = ST_PSUB;
      ST_PSUB: if (tcnt_last) st_d = ST_PUPD;
      ST_PUPD: st_d = ST_WRITE;
      ST_WRITE: st_d = ST_OUT;
      ST_SCAN: if (cnt_last) st_d = ST_DRAIN;
      ST_DRAIN: st_d = ST_DECIDE;
      ST_DECIDE: begin
        if (r_due || !pany_q) st_d = ST_OUT;
        else st_d = ST_DDIV;
      end
      ST_DDIV: if (div_done) st_d = ST_DEC;
      ST_DEC: if (cnt_last) st_d = ST_DECEND;
      ST_DECEND: st_d = ST_OUT;
      ST_OUT: if (!out_valid_q || out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ controls
  assign r_due = rany_q && (rmin_q <= now_q);

  always_comb begin
    in_ready_o   = (st_q == ST_IDLE);
    div_start    = 1'b0;
    div_dividend = {PROD_W'(MS_PER_S), 16'b0};
    div_divisor  = rrate_eff;
    prod         = PROD_W'(MS_PER_S * in_q.rho);
    mem_re       = (st_q == ST_SCAN) || (st_q == ST_DEC);
    out_load     = (st_q == ST_OUT) && (!out_valid_q || out_ready_i);
    unique case (st_q)
      ST_FREE: begin
        div_start    = !valid_q[cnt_q];
        div_dividend = {prod, 16'b0};
      end
      ST_RDIV: begin
        div_start    = div_done;
        prod         = PROD_W'(MS_PER_S * in_q.delta);
        div_dividend = {prod, 16'b0};
        div_divisor  = lrate_eff;
      end
      ST_DECIDE: div_start = !r_due && pany_q;
      default: ;
    endcase
  end

  // pending memory write port: new entry on insert, decrement sweep otherwise
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_idx_q;
    mem_wdata = rd_q;
    if (st_q == ST_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = slot_q;
      mem_wdata.request = in_q.request_id;
      mem_wdata.tenant  = 4'(ten_q);
      mem_wdata.rtag    = rtag_q[ten_q];
      mem_wdata.ltag    = ltag_q[ten_q];
      mem_wdata.ptag    = ptag_q[ten_q];
    end else if (pend_q && pend_dec_q && rd_q.tenant == gten_q) begin
      mem_we        = 1'b1;
      mem_wdata.rtag = (rd_q.rtag > dec_tag) ? rd_q.rtag - dec_tag : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[cnt_q];
  end

  assign r_better = !rany_q || (rd_q.rtag < rmin_q);
  assign p_better = (rd_q.ltag <= now_q) && (!pany_q || (rd_q.ptag < pmin_q));

  // ------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      tcnt_q      <= '0;
      valid_q     <= '0;
      pend_q      <= 1'b0;
      pend_dec_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rany_q      <= 1'b0;
      pany_q      <= 1'b0;
      pm_any_q    <= 1'b0;
      for (int i = 0; i < TENANTS; i++) begin
        rtag_q[i] <= '0;
        ltag_q[i] <= '0;
        ptag_q[i] <= '0;
      end
    end else begin
      st_q       <= st_d;
      pend_q     <= mem_re && valid_q[cnt_q];
      pend_dec_q <= (st_q == ST_DEC);

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (st_q == ST_FREE || st_q == ST_SCAN || st_q == ST_DEC) cnt_q <= cnt_q + 1'b1;
      if (st_q == ST_DDIV || st_q == ST_IDLE) cnt_q <= '0;
      if (tcnt_last || st_q == ST_IDLE) tcnt_q <= '0;
      else if (st_q == ST_PMIN || st_q == ST_PSUB) tcnt_q <= tcnt_q + 1'b1;

      if (st_q == ST_IDLE) begin
        rany_q   <= 1'b0;
        pany_q   <= 1'b0;
        pm_any_q <= 1'b0;
      end
      if (pend_q && !pend_dec_q) begin
        if (r_better) rany_q <= 1'b1;
        if (p_better) pany_q <= 1'b1;
      end

      unique case (st_q)
        ST_RDIV: if (div_done) begin
          rtag_q[ten_q] <= tag_max(sat_add(rtag_q[ten_q], TAG_W'(div_quot)), now_q);
        end
        ST_LDIV: if (div_done) begin
          ltag_q[ten_q] <= tag_max(sat_add(ltag_q[ten_q], TAG_W'(div_quot)), now_q);
        end
        ST_PMIN: if (ptag_q[tcnt_q] != '0 && (!pm_any_q || ptag_q[tcnt_q] < pm_q)) begin
          pm_any_q <= 1'b1;
        end
        ST_PSUB: if (pm_any_q && ptag_q[tcnt_q] != '0) begin
          ptag_q[tcnt_q] <= ptag_q[tcnt_q] - pm_q;
        end
        ST_PUPD: ptag_q[ten_q] <= tag_max(sat_add(ptag_q[ten_q], MS_ONE), now_q);
        ST_WRITE: valid_q[slot_q] <= 1'b1;
        ST_DECIDE: begin
          if (r_due) valid_q[rmin_idx_q] <= 1'b0;
          else if (pany_q) valid_q[pmin_idx_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      in_q  <= in_data_i;
      ten_q <= ten_idx;
      now_q <= {in_data_i.now_ms, 16'b0};
    end
    if (st_q == ST_FREE) slot_q <= cnt_q;
    if (st_q == ST_PMIN && ptag_q[tcnt_q] != '0 && (!pm_any_q || ptag_q[tcnt_q] < pm_q))
      pm_q <= ptag_q[tcnt_q];
    if (mem_re) pend_idx_q <= cnt_q;
    if (st_q == ST_DDIV && div_done) dec_q <= div_quot;

    if (pend_q && !pend_dec_q) begin
      if (r_better) begin
        rmin_q     <= rd_q.rtag;
        rmin_id_q  <= rd_q.request;
        rmin_ten_q <= rd_q.tenant;
        rmin_idx_q <= pend_idx_q;
      end
      if (p_better) begin
        pmin_q     <= rd_q.ptag;
        pmin_id_q  <= rd_q.request;
        pmin_ten_q <= rd_q.tenant;
        pmin_idx_q <= pend_idx_q;
      end
    end

    // result of the beat, held until the output register is free
    unique case (st_q)
      ST_FREE: res_q <= '{status: STAT_DROPPED, granted_id: '0,
                          granted_tenant: '0, method: METHOD_RES};
      ST_WRITE: res_q <= '{status: STAT_QUEUED, granted_id: '0,
                           granted_tenant: '0, method: METHOD_RES};
      ST_DECIDE: begin
        gten_q <= pmin_ten_q;
        gidx_q <= pmin_idx_q;
        if (r_due) begin
          res_q <= '{status: STAT_GRANTED, granted_id: rmin_id_q,
                     granted_tenant: rmin_ten_q, method: METHOD_RES};
        end else if (pany_q) begin
          res_q <= '{status: STAT_GRANTED, granted_id: pmin_id_q,
                     granted_tenant: pmin_ten_q, method: METHOD_WEIGHT};
        end else begin
          res_q <= '{status: STAT_NONE, granted_id: '0,
                     granted_tenant: '0, method: METHOD_RES};
        end
      end
      default: ;
    endcase

    if (out_load) out_q <= res_q;
  end

  rlwts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- assertions
  // the divider is never left running once the sequencer is back to idle
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while idle");

  // memory read data is only consumed after a scan or decrement read
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(st_q) == ST_SCAN || $past(st_q) == ST_DEC))
    else $error("stray pending read");

  // the weight-granted slot stays free during the decrement sweep
  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DEC) |-> !valid_q[gidx_q])
    else $error("granted slot still valid");

endmodule

// ===== rtl/rlwts_div.sv =====
// ----------------------------------------------------------------------------
// rlwts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rlwts_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rlwts_pkg::DIV_NW-1:0]        dividend_i,
  input  logic [rlwts_pkg::RATE_W-1:0]        divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [rlwts_pkg::DIV_NW-1:0]        quot_o
);
  import rlwts_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] work_q;
  logic [RATE_W-1:0] rem_q, dvs_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [RATE_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, work_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? RATE_W'(trial - {1'b0, dvs_q}) : trial[RATE_W-1:0];
      work_q <= {work_q[DIV_NW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = work_q;

endmodule
